// ===== hdl/ptrd_pkg.sv =====
package ptrd_pkg;

	localparam int ROW_W    = 6;
	localparam int CELL_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int PHASE_W  = 2;

	localparam logic [BYTE_W-1:0] CODE_MASK  = 8'hF0;
	localparam logic [BYTE_W-1:0] CODE_FULLA = 8'h00;
	localparam logic [BYTE_W-1:0] CODE_FULLB = 8'h10;
	localparam logic [BYTE_W-1:0] CODE_FX    = 8'h40;
	localparam logic [BYTE_W-1:0] CODE_NOTE  = 8'h80;
	localparam logic [BYTE_W-1:0] LO_MASK    = 8'h0F;
	localparam logic [BYTE_W-1:0] RUN_BASE   = 8'hC0;

	// bytes that follow a lead byte; none means an empty run
	localparam logic [PHASE_W-1:0] TAIL_RUN  = 2'd0;
	localparam logic [PHASE_W-1:0] TAIL_FX   = 2'd1;
	localparam logic [PHASE_W-1:0] TAIL_NOTE = 2'd2;
	localparam logic [PHASE_W-1:0] TAIL_FULL = 2'd3;

	typedef struct packed {
		logic              load;       // a byte was accepted
		logic              rst_row;    // restart the track at row 0
		logic              emit;       // one finished cell
		logic              run;        // an empty run
		logic [BYTE_W-1:0] run_cnt;    // cells in the run minus one
		logic [CELL_W-1:0] cell_data;
	} emit_req_t;

	function automatic logic [PHASE_W-1:0] tail_len(input logic [BYTE_W-1:0] lead);
		logic [BYTE_W-1:0] code;
		code = lead & CODE_MASK;
		if (code == CODE_FULLA || code == CODE_FULLB)
			return TAIL_FULL;
		else if (code == CODE_FX)
			return TAIL_FX;
		else if (code == CODE_NOTE)
			return TAIL_NOTE;
		else
			return TAIL_RUN;
	endfunction

endpackage

// ===== hdl/packed_track_row_decoder.sv =====
// Packed track row decoder.
// Slave channel (s_*): one packed track byte per transaction in s_tdata;
// s_tuser[0] marks the first byte of a track and restarts at row 0,
// dropping any partly received cell.
// Master channel (m_*): one 4-byte row cell per transaction. m_tdata holds
// the cell and its row index, m_tlast marks the final cell caused by one
// input byte, m_tuser[0] marks the final row of the track.
// Throughput: note and effect bytes flow back to back while the output is
// free; the byte that completes a cell loads the output register in the
// same cycle, and m_tvalid rises in the next. After a run lead byte the
// run sequencer enters its run state, then emits the zero cells one per
// cycle while the receiver takes them, via a row/count compare; s_tready
// stays low until the last cell of the run is loaded.
// The output register lets the next byte in while a cell waits, as long
// as the receiver takes it; a stalled receiver holds m_tvalid and the
// cell stable and holds s_tready low.
// Reset clears the byte phase, the row count and the output valid.
module packed_track_row_decoder
	import ptrd_pkg::*;
#(
	parameter int ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] packed_byte
	input  logic [0:0]  s_tuser,   // [0] track_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] cell_res, [37:32] row_index, [39:38] zero
	output logic        m_tlast,   // last_in_run
	output logic [0:0]  m_tuser    // [0] last_of_track
);

	logic [PHASE_W-1:0] phase_q;
	logic [BYTE_W-1:0]  lead_q;
	logic [BYTE_W-1:0]  held0_q;
	logic [BYTE_W-1:0]  held1_q;

	logic               accept;
	logic               start;
	logic [PHASE_W-1:0] phase_eff;
	logic [PHASE_W-1:0] need_new;
	logic [PHASE_W-1:0] need_held;
	logic [BYTE_W-1:0]  lo;
	logic [CELL_W-1:0]  cell_data;
	emit_req_t          req;
	logic               em_ready;
	logic [CELL_W-1:0]  out_cell;
	logic [ROW_W-1:0]   out_row;

	assign accept    = s_tvalid && s_tready;
	assign start     = s_tuser[0];
	// track start drops a partial cell: treat this byte as a lead byte
	assign phase_eff = start ? TAIL_RUN : phase_q;
	assign need_new  = tail_len(s_tdata);
	assign need_held = tail_len(lead_q);
	assign lo        = lead_q & LO_MASK;

	// assemble the finished cell from the held bytes and the final byte
	always_comb begin
		case (need_held)
			TAIL_FULL: cell_data = {lead_q, held0_q, held1_q, s_tdata};
			TAIL_FX:   cell_data = {16'h0000, lo, s_tdata};
			TAIL_NOTE: cell_data = {held0_q, s_tdata, lo[3:0], 4'h0, 8'h00};
			default:   cell_data = '0;
		endcase
	end

	always_comb begin
		req.load      = accept;
		req.rst_row   = start;
		req.emit      = (phase_eff != TAIL_RUN) && (phase_eff >= need_held);
		req.run       = (phase_eff == TAIL_RUN) && (need_new == TAIL_RUN);
		req.run_cnt   = s_tdata - RUN_BASE;
		req.cell_data = cell_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			lead_q  <= '0;
			held0_q <= '0;
			held1_q <= '0;
		end else if (accept) begin
			if (phase_eff == TAIL_RUN) begin
				// lead byte: hold it unless it opens an empty run
				if (need_new != TAIL_RUN) begin
					lead_q  <= s_tdata;
					phase_q <= PHASE_W'(1);
				end else begin
					phase_q <= '0;
				end
			end else if (phase_eff < need_held) begin
				if (phase_eff == PHASE_W'(1))
					held0_q <= s_tdata;
				else
					held1_q <= s_tdata;
				phase_q <= phase_eff + 1'b1;
			end else begin
				phase_q <= '0;
			end
		end
	end

	assign s_tready = em_ready;

	ptrd_emitter #(
		.ROWS(ROWS)
	) u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.ready         (em_ready),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_cell      (out_cell),
		.out_row       (out_row),
		.out_last_run  (m_tlast),
		.out_last_track(m_tuser[0])
	);

	assign m_tdata = {2'b00, out_row, out_cell};

endmodule

// ===== hdl/ptrd_emitter.sv =====
module ptrd_emitter
	import ptrd_pkg::*;
#(
	parameter int ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  emit_req_t         req,
	output logic              ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CELL_W-1:0] out_cell,
	output logic [ROW_W-1:0]  out_row,
	output logic              out_last_run,
	output logic              out_last_track
);

	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [ROW_W-1:0]   row_q;
	logic [BYTE_W-1:0]  cnt_q;
	logic               valid_q;
	logic [CELL_W-1:0]  cell_q;
	logic [ROW_W-1:0]   orow_q;
	logic               olast_q;
	logic               otrk_q;

	logic               out_free;
	logic [ROW_W-1:0]   row_eff;
	logic               at_end;
	logic [ROW_W-1:0]   row_next;
	logic               run_last;

	assign out_free = !valid_q || out_ready;
	assign ready    = (state_q == ST_IDLE) && out_free;
	assign row_eff  = req.rst_row ? '0 : row_q;
	assign at_end   = (row_eff == ROW_LAST);
	assign row_next = at_end ? '0 : row_eff + 1'b1;
	// run_last stops the run at its count or at the end of the track
	assign run_last = (cnt_q == '0) || (row_q == ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.load && req.emit) begin
						valid_q <= 1'b1;
						row_q   <= row_next;
					end else begin
						if (out_ready)
							valid_q <= 1'b0;
						if (req.load) begin
							row_q <= row_eff;
							if (req.run) begin
								cnt_q   <= req.run_cnt;
								state_q <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					if (out_free) begin
						valid_q <= 1'b1;
						cnt_q   <= cnt_q - 1'b1;
						row_q   <= (row_q == ROW_LAST) ? '0 : row_q + 1'b1;
						if (run_last)
							state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.load && req.emit) begin
			cell_q  <= req.cell_data;
			orow_q  <= row_eff;
			olast_q <= 1'b1;
			otrk_q  <= at_end;
		end else if (state_q == ST_RUN && out_free) begin
			cell_q  <= '0;
			orow_q  <= row_q;
			olast_q <= run_last;
			otrk_q  <= (row_q == ROW_LAST);
		end
	end

	assign out_valid      = valid_q;
	assign out_cell       = cell_q;
	assign out_row        = orow_q;
	assign out_last_run   = olast_q;
	assign out_last_track = otrk_q;

endmodule

// ===== hdl/ptrd_checker.sv =====
module ptrd_checker #(
	parameter int ROWS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	localparam logic [5:0] ROW_LAST = 6'(ROWS - 1);

	// a stalled cell stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	// last-of-track flag agrees with the row index
	a_track_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] == (m_tdata[37:32] == ROW_LAST)))
		else $error("last_of_track does not match row_index");

	// the final row of the track always closes a run
	a_run_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("run continues past the final row");

	// input stays blocked while a run cell that is not the last one is offered
	a_run_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input open in the middle of a run");

endmodule

bind packed_track_row_decoder ptrd_checker #(.ROWS(ROWS)) u_ptrd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

// ===== sim/tb.sv =====
module tb;
	import ptrd_pkg::*;

	localparam int TRACK_ROWS  = 64;
	localparam int IDLE_LIMIT  = 2000;   // cycles with no transaction on either side
	localparam int DRAIN_WAIT  = 16;     // extra wait after the last expected cell came back
	localparam int RANDOM_BYTES = 230;
	localparam int HOLD_FROM   = 300;    // receiver cycle window of the long hold-off
	localparam int HOLD_TO     = 560;

	// one packed byte waiting to be offered on the slave side
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              start;
	} track_byte_t;

	// one row cell as the decoder should deliver it
	typedef struct {
		logic [CELL_W-1:0] cell_word;
		logic [ROW_W-1:0]  row;
		logic              run_end;
		logic              track_end;
	} row_cell_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	track_byte_t bytes_to_send[$];
	row_cell_t   cells_due[$];
	track_byte_t byte_nxt;
	row_cell_t   cell_exp;

	// shadow of the decoder state
	int                unsigned trk_phase;
	logic [BYTE_W-1:0] trk_lead;
	logic [BYTE_W-1:0] trk_held[2];
	int                unsigned trk_row;

	int mismatches = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rx_cyc = 0;
	int idle_cyc = 0;

	packed_track_row_decoder #(.ROWS(TRACK_ROWS)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] packed_byte
		.s_tuser  (s_tuser),    // [0] track_start
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [31:0] cell_res, [37:32] row_index, [39:38] zero
		.m_tlast  (m_tlast),    // last_in_run
		.m_tuser  (m_tuser)     // [0] last_of_track
	);

	always #2 clk = ~clk;

	// Number of bytes that follow a lead byte; zero marks an empty run.
	function automatic int unsigned tail_bytes(logic [BYTE_W-1:0] lead);
		logic [BYTE_W-1:0] code;
		code = lead & CODE_MASK;
		if (code == CODE_FULLA || code == CODE_FULLB)
			return 3;
		if (code == CODE_FX)
			return 1;
		if (code == CODE_NOTE)
			return 2;
		return 0;
	endfunction

	// Queue one cell at the current row and advance the row, wrapping at the track end.
	function automatic void queue_row_cell(logic [CELL_W-1:0] word, logic run_end);
		row_cell_t c;
		c.cell_word = word;
		c.row       = trk_row[ROW_W-1:0];
		c.run_end   = run_end;
		c.track_end = (trk_row + 1 >= TRACK_ROWS);
		cells_due.push_back(c);
		trk_row = (trk_row + 1 >= TRACK_ROWS) ? 0 : trk_row + 1;
	endfunction

	// Advance the shadow state by one accepted byte and queue the cells it completes.
	function automatic void decode_track_byte(logic [BYTE_W-1:0] b, logic start);
		int unsigned       need;
		int unsigned       run_len;
		logic [BYTE_W-1:0] run_off;
		logic [CELL_W-1:0] word;
		logic [3:0]        lo;
		if (start) begin
			trk_phase = 0;
			trk_row   = 0;
		end
		if (trk_phase == 0) begin
			need = tail_bytes(b);
			if (need == 0) begin
				// empty run: clamp to the rows left in the track
				run_off = b - RUN_BASE;
				run_len = run_off + 1;
				if (run_len > TRACK_ROWS - trk_row)
					run_len = TRACK_ROWS - trk_row;
				for (int i = 0; i < run_len; i++)
					queue_row_cell('0, i + 1 == run_len);
			end else begin
				trk_lead  = b;
				trk_phase = 1;
			end
			return;
		end
		need = tail_bytes(trk_lead);
		if (trk_phase < need) begin
			trk_held[trk_phase - 1] = b;
			trk_phase++;
			return;
		end
		// final byte of the cell
		trk_phase = 0;
		lo = trk_lead[3:0];
		if (need == 3)
			word = {trk_lead, trk_held[0], trk_held[1], b};
		else if (need == 1)
			word = {16'h0000, 4'h0, lo, b};
		else
			word = {trk_held[0], b, lo, 4'h0, 8'h00};
		queue_row_cell(word, 1'b1);
	endfunction

	task automatic flag_mismatch(string what, logic [CELL_W-1:0] got, logic [CELL_W-1:0] want);
		$display("MISMATCH %s: got %h, expected %h", what, got, want);
		mismatches++;
	endtask

	task automatic add_byte(logic [BYTE_W-1:0] b, logic start);
		track_byte_t t;
		t.data  = b;
		t.start = start;
		bytes_to_send.push_back(t);
	endtask

	// Sender: offer queued bytes in bursts of random length, idle after most bursts.
	// Hold data stable while a transaction is pending; advance only on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left <= 1;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				decode_track_byte(s_tdata, s_tuser[0]);
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (bytes_to_send.size() > 0) begin
				byte_nxt = bytes_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= byte_nxt.data;
				s_tuser  <= byte_nxt.start;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					// a third of the bursts run straight into the next one
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: step through four stall patterns in turn; hold off for a long
	// stretch once so the decoder fills up and drops s_tready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cyc   <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (rx_cyc >= HOLD_FROM && rx_cyc < HOLD_TO)
				m_tready <= 1'b0;
			else begin
				case ((rx_cyc / 256) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 0);
					2: m_tready <= (rx_cyc % 3 == 0);
					default: m_tready <= ($urandom_range(0, 99) < 85);
				endcase
			end
		end
	end

	// Monitor: compare every delivered cell with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cells_due.size() == 0) begin
				flag_mismatch("cell with none expected", m_tdata[31:0], '0);
			end else begin
				cell_exp = cells_due.pop_front();
				if (m_tdata[31:0] !== cell_exp.cell_word)
					flag_mismatch("cell_res", m_tdata[31:0], cell_exp.cell_word);
				if (m_tdata[37:32] !== cell_exp.row)
					flag_mismatch("row_index", CELL_W'(m_tdata[37:32]),
						CELL_W'(cell_exp.row));
				if (m_tlast !== cell_exp.run_end)
					flag_mismatch("last_in_run", CELL_W'(m_tlast), CELL_W'(cell_exp.run_end));
				if (m_tuser[0] !== cell_exp.track_end)
					flag_mismatch("last_of_track", CELL_W'(m_tuser[0]),
						CELL_W'(cell_exp.track_end));
			end
		end
	end

	// Watchdog: end the run when neither side moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cyc <= 0;
			else if (idle_cyc >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else
				idle_cyc <= idle_cyc + 1;
		end
	end

	initial begin
		int unsigned kind;
		logic [3:0]  nib;
		logic        st;

		trk_phase   = 0;
		trk_lead    = '0;
		trk_held[0] = '0;
		trk_held[1] = '0;
		trk_row     = 0;

		// directed: field extremes, every code, and the special cases
		add_byte(8'h00, 1'b1); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h1F, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'h4F, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'h40, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h8F, 1'b0); add_byte(8'hAB, 1'b0); add_byte(8'hCD, 1'b0);
		add_byte(8'h80, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'hFF, 1'b0);
		add_byte(8'hC0, 1'b0);                       // one empty row
		add_byte(8'hFF, 1'b0);                       // run past the track end: clamp
		add_byte(8'hBF, 1'b0);                       // longest run from row 0: whole track
		// track start inside a full cell drops the partial cell
		add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0);
		add_byte(8'h4A, 1'b1); add_byte(8'h99, 1'b0);

		// random: mostly well-formed cells with random content, some runs and noise
		while (bytes_to_send.size() < 25 + RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			st   = ($urandom_range(0, 19) == 0);
			nib  = 4'($urandom_range(0, 15));
			if (kind < 35) begin
				add_byte({3'b000, 1'($urandom_range(0, 1)), nib}, st);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else if (kind < 55) begin
				add_byte(CODE_FX | nib, st);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else if (kind < 75) begin
				add_byte(CODE_NOTE | nib, st);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
			end else if (kind < 87) begin
				add_byte(RUN_BASE | nib, st);        // short empty run
			end else if (kind < 91) begin
				// any other run code, mostly clamped at the track end
				logic [3:0] hi;
				do hi = 4'($urandom_range(2, 15)); while (hi == 4'h4 || hi == 4'h8);
				add_byte({hi, nib}, st);
			end else if (kind < 97) begin
				add_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				// truncated cell, then a restart of the track
				add_byte(CODE_NOTE | nib, 1'b0);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
				add_byte(CODE_FX | nib, 1'b1);
				add_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait until every byte went out and every expected cell came back
		while (bytes_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== packed_track_row_decoder.f =====
hdl/ptrd_pkg.sv
hdl/ptrd_emitter.sv
hdl/packed_track_row_decoder.sv
hdl/ptrd_checker.sv
sim/tb.sv
